@@ hdl/mprq_pkg.sv @@
// ----------------------------------------------------------------------------
// mprq_pkg
// Types, sizes and codes shared by the packet ring queue modules.
// ----------------------------------------------------------------------------
package mprq_pkg;

  localparam int CHANNELS     = 4;
  localparam int QUEUE_SLOTS  = 8;
  localparam int PACKET_BYTES = 64;

  localparam int NSLOTS     = CHANNELS * QUEUE_SLOTS;
  localparam int DATA_DEPTH = NSLOTS * PACKET_BYTES;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QS_W       = $clog2(QUEUE_SLOTS);
  localparam int SLOT_W     = $clog2(NSLOTS);
  localparam int ADDR_W     = $clog2(DATA_DEPTH);
  localparam int OFF_W      = $clog2(PACKET_BYTES + 1);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_READ_BYTE = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_TOO_SMALL = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  channel;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [11:0] length_value;
  } req_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [6:0] stored_length;
    logic       last_result;
  } rsp_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_STREAM
  } ctl_state_t;

  typedef struct packed {
    logic      push;
    rsp_word_t word;
  } q_push_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } q_stat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } dmem_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [OFF_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } lmem_req_t;

endpackage

@@ hdl/mprq_ram.sv @@
// ----------------------------------------------------------------------------
// mprq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mprq_outq.sv @@
// ----------------------------------------------------------------------------
// mprq_outq
// Two-word output queue; decouples the response channel from the core.
// ----------------------------------------------------------------------------
module mprq_outq (
  input  logic               clk,
  input  logic               rst,
  input  mprq_pkg::q_push_t  push,
  output mprq_pkg::q_stat_t  stat,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mprq_pkg::rsp_word_t rsp
);
  import mprq_pkg::*;

  rsp_word_t  mem [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop        = (count != 2'd0) && !rsp_stall;
  assign rsp_valid  = (count != 2'd0);
  assign rsp        = mem[rd_ptr];
  assign stat.count = count;
  assign stat.pop   = pop;

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push.push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/mprq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mprq_ctrl
// Queue sequencer: ring indices, full marks, write assembly, read streaming.
// ----------------------------------------------------------------------------
module mprq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mprq_pkg::req_word_t req,
  output mprq_pkg::dmem_req_t dmem,
  input  logic [7:0]          dmem_rdata,
  output mprq_pkg::lmem_req_t lmem,
  input  logic [mprq_pkg::OFF_W-1:0] lmem_rdata,
  output mprq_pkg::q_push_t   qpush,
  input  mprq_pkg::q_stat_t   qstat
);
  import mprq_pkg::*;

  ctl_state_t state, state_next;

  logic [QS_W-1:0]   head [CHANNELS];
  logic [QS_W-1:0]   tail [CHANNELS];
  logic [NSLOTS-1:0] slot_full;
  logic [OFF_W-1:0]  wo;
  logic              rej;

  logic [SLOT_W-1:0] slot_q;
  logic [CH_W-1:0]   ch_q;
  logic [11:0]       cap_q;
  logic              full_q;
  logic [OFF_W-1:0]  n_q;
  logic [OFF_W-1:0]  idx;
  logic              inflight;
  logic              inflight_last;

  logic              accept;
  logic              room;
  logic [2:0]        occ;
  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [SLOT_W-1:0] ch_base;
  logic [SLOT_W-1:0] hslot;
  logic [SLOT_W-1:0] tslot;
  logic              is_write;
  logic              is_read;
  logic              is_clear;
  logic              rej_new;
  logic              store;
  logic [OFF_W-1:0]  wo_after;
  logic              issue;
  logic              idx_last;
  logic              release_slot;
  logic              len_fits;

  assign occ    = {1'b0, qstat.count} + {2'b0, inflight} - {2'b0, qstat.pop};
  assign room   = (occ <= 3'd1);
  assign accept = req_valid && !req_stall;

  assign ch_ok   = (32'(req.channel) < 32'(CHANNELS));
  assign ch_idx  = CH_W'(req.channel);
  assign ch_base = SLOT_W'(SLOT_W'(ch_idx) * SLOT_W'(QUEUE_SLOTS));
  assign hslot   = ch_base + SLOT_W'(head[ch_idx]);
  assign tslot   = ch_base + SLOT_W'(tail[ch_idx]);

  assign is_write = accept && (req.cmd == CMD_WRITE) && ch_ok;
  assign is_read  = accept && (req.cmd == CMD_READ) && ch_ok;
  assign is_clear = accept && (req.cmd == CMD_CLEAR);

  assign rej_new  = rej || (32'(req.length_value) > 32'(PACKET_BYTES));
  assign store    = !rej_new && (32'(wo) < 32'(req.length_value))
                    && (32'(wo) < 32'(PACKET_BYTES));
  assign wo_after = store ? wo + OFF_W'(1) : wo;

  assign len_fits = (32'(lmem_rdata) <= 32'(cap_q));
  assign idx_last = (idx == n_q - OFF_W'(1));

  always_comb begin
    dmem.we    = is_write && store;
    dmem.waddr = ADDR_W'(ADDR_W'(hslot) * ADDR_W'(PACKET_BYTES)) + ADDR_W'(wo);
    dmem.wdata = req.data_byte;
    dmem.raddr = ADDR_W'(ADDR_W'(slot_q) * ADDR_W'(PACKET_BYTES)) + ADDR_W'(idx);
    lmem.we    = is_write && req.last_byte && !rej_new;
    lmem.waddr = hslot;
    lmem.wdata = wo_after;
    lmem.raddr = tslot;
  end

  always_comb begin
    state_next   = state;
    req_stall    = 1'b1;
    issue        = 1'b0;
    release_slot = 1'b0;
    qpush.push   = 1'b0;
    qpush.word   = '0;
    unique case (state)
      S_IDLE: begin
        req_stall = !(room && !inflight);
        if (inflight) begin
          qpush.push = 1'b1;
          qpush.word = '{ST_READ_BYTE, dmem_rdata, 7'(n_q), inflight_last};
        end else if (is_write) begin
          qpush.push = 1'b1;
          qpush.word = '{rej_new ? ST_TOO_LONG : ST_WRITTEN, 8'd0, 7'd0, 1'b1};
        end else if (is_clear) begin
          qpush.push = 1'b1;
          qpush.word = '{ST_CLEARED, 8'd0, 7'd0, 1'b1};
        end
        if (is_read) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        qpush.push = 1'b1;
        state_next = S_IDLE;
        if (!full_q) begin
          qpush.word = '{ST_EMPTY, 8'd0, 7'd0, 1'b1};
        end else if (!len_fits) begin
          qpush.word = '{ST_TOO_SMALL, 8'd0, 7'(lmem_rdata), 1'b1};
        end else begin
          release_slot = 1'b1;
          if (lmem_rdata == '0) begin
            qpush.word = '{ST_READ_BYTE, 8'd0, 7'd0, 1'b1};
          end else begin
            qpush.push = 1'b0;
            state_next = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        if (inflight) begin
          qpush.push = 1'b1;
          qpush.word = '{ST_READ_BYTE, dmem_rdata, 7'(n_q), inflight_last};
        end
        issue = room;
        if (room && idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full     <= '0;
      wo            <= '0;
      rej           <= 1'b0;
      inflight      <= 1'b0;
      inflight_last <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      inflight      <= issue;
      inflight_last <= idx_last;
      if (is_clear) begin
        slot_full <= '0;
        wo        <= '0;
        rej       <= 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
          head[i] <= '0;
          tail[i] <= '0;
        end
      end else if (is_write) begin
        if (req.last_byte) begin
          wo  <= '0;
          rej <= 1'b0;
          if (!rej_new) begin
            slot_full[hslot] <= 1'b1;
            head[ch_idx] <= (head[ch_idx] == QS_W'(QUEUE_SLOTS - 1)) ? '0
                            : head[ch_idx] + QS_W'(1);
          end
        end else begin
          wo  <= wo_after;
          rej <= rej_new;
        end
      end else if (release_slot) begin
        slot_full[slot_q] <= 1'b0;
        tail[ch_q] <= (tail[ch_q] == QS_W'(QUEUE_SLOTS - 1)) ? '0
                      : tail[ch_q] + QS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      slot_q <= tslot;
      ch_q   <= ch_idx;
      cap_q  <= req.length_value;
      full_q <= slot_full[tslot];
    end
    if (state == S_LEN) begin
      n_q <= lmem_rdata;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + OFF_W'(1);
    end
  end

endmodule

@@ hdl/multichannel_packet_ring_queue.sv @@
// ----------------------------------------------------------------------------
// multichannel_packet_ring_queue
// Per-channel rings of packet slots held in RAM; packets are written one
// byte per word and read back as a stream of bytes.
// ----------------------------------------------------------------------------
//   Channel | Dir | Handshake            | Word
//   req     | in  | req_valid/req_stall  | req_word_t (cmd, channel, byte,...)
//   rsp     | out | rsp_valid/rsp_stall  | rsp_word_t (status, byte, length)
//
// Write and clear words each answer with one word.
// A read is accepted, then its length is looked up in the length RAM; an
// n-byte packet then streams one byte per cycle while the response side has
// room, and req_stall is held until the last byte is queued.
// Synchronous reset clears the full marks, ring indices and write state.
// The response side holds two words; rsp_stall backs up into req_stall.
// ----------------------------------------------------------------------------
module multichannel_packet_ring_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mprq_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mprq_pkg::rsp_word_t rsp
);
  import mprq_pkg::*;

  dmem_req_t        dmem;
  lmem_req_t        lmem;
  logic [7:0]       dmem_rdata;
  logic [OFF_W-1:0] lmem_rdata;
  q_push_t          qpush;
  q_stat_t          qstat;

  mprq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .dmem       (dmem),
    .dmem_rdata (dmem_rdata),
    .lmem       (lmem),
    .lmem_rdata (lmem_rdata),
    .qpush      (qpush),
    .qstat      (qstat)
  );

  mprq_ram #(
    .WIDTH (8),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (dmem.we),
    .waddr (dmem.waddr),
    .wdata (dmem.wdata),
    .raddr (dmem.raddr),
    .rdata (dmem_rdata)
  );

  mprq_ram #(
    .WIDTH (OFF_W),
    .DEPTH (NSLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (lmem.we),
    .waddr (lmem.waddr),
    .wdata (lmem.wdata),
    .raddr (lmem.raddr),
    .rdata (lmem_rdata)
  );

  mprq_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (qpush),
    .stat      (qstat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
